// ===== design/thermistor_adc_to_temperature_macros.svh =====
// assertion macros for the thermistor converter
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TADC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tadc check failed");

// next-cycle implication
`define TADC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tadc check failed");

`endif

// ===== design/tadc_pkg.sv =====
// shared constants, segment tables and structs for the thermistor converter
// no dependencies
`timescale 1ns / 1ps

package tadc_pkg;

  // field and datapath widths
  localparam int ADC_CODE_W   = 10;
  localparam int ADC_BITS_DEF = 10;
  localparam int MV_W         = 12;
  localparam int NUM_W        = 25;
  localparam int DEN_W        = 13;
  localparam int Q_W          = 16;
  localparam int QT_W         = 10;
  localparam int CNT_W        = 5;
  localparam int R_W          = 16;
  localparam int DIFF_W       = 14;
  localparam int SCALE_W      = 10;
  localparam int NUM2_W       = 23;
  localparam int T_W          = 13;
  localparam int SEG_N        = 6;

  // divider constants
  localparam logic [MV_W-1:0]    VREF_MV    = 12'd3300;
  localparam logic [R_W-1:0]     SERIES_OHM = 16'd10000;
  localparam logic [SCALE_W-1:0] SCALE_LO   = 10'd100;
  localparam logic [SCALE_W-1:0] SCALE_HI   = 10'd1000;
  localparam logic [T_W-1:0]     T_MAX      = 13'd5999;

  // segment tables, open at both ends, hottest last
  localparam logic [R_W-1:0] SEG_TOP [SEG_N] = '{
    16'd33970, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586};
  localparam logic [R_W-1:0] SEG_BOT [SEG_N] = '{
    16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
  localparam logic [DEN_W-1:0] SEG_SLOPE [SEG_N] = '{
    13'd1366, 13'd774, 13'd4537, 13'd2737, 13'd1717, 13'd1102};
  localparam logic SEG_FINE [SEG_N] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic [T_W-1:0] SEG_BASE [SEG_N] = '{
    13'd0, 13'd1000, 13'd2000, 13'd3000, 13'd4000, 13'd5000};

  // request to the serial divider
  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] hi;
    logic [Q_W-1:0]   lo;
    logic [CNT_W-1:0] cnt;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  // segment lookup result
  typedef struct packed {
    logic              hit;
    logic [DIFF_W-1:0] diff;
    logic              fine;
    logic [DEN_W-1:0]  slope;
    logic [T_W-1:0]    base;
  } seg_info_t;

endpackage

// ===== design/tadc_if.sv =====
// valid/ready channel interfaces for adc words and temperature words
// depends on tadc_pkg
`timescale 1ns / 1ps

interface tadc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tadc_pkg::ADC_CODE_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface tadc_out_if;
  logic                    valid;
  logic                    ready;
  logic [tadc_pkg::T_W-1:0] temp_centi;
  logic                    in_range;

  modport source (output valid, output temp_centi, output in_range, input ready);
  modport sink   (input valid, input temp_centi, input in_range, output ready);
endinterface

// ===== design/thermistor_adc_to_temperature.sv =====
// an accepted word is scaled to millivolts and to the divider numerator, the divider
// resolves its resistance and the segment lookup follows; only an in-range reading takes
// the second pass of the shared bit-serial divider (16 then 10 quotient bits), and a
// resistance over 16 bits skips both passes; one word at a time, the next is taken only
// once the result register is loaded; reset: held temperature clears to zero, channels empty, result register free
`timescale 1ns / 1ps

`include "thermistor_adc_to_temperature_macros.svh"

module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = tadc_pkg::ADC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tadc_in_if.sink           adc_i,
  tadc_out_if.source        temp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MV, S_NUM, S_D1, S_W1, S_SEG, S_MUL, S_D2, S_W2, S_OUT
  } state_e;

  localparam int PROD_W = ADC_BITS + tadc_pkg::MV_W;
  localparam int NUM_PROD_W = tadc_pkg::MV_W + tadc_pkg::R_W;
  localparam int PROD2_W = tadc_pkg::DIFF_W + tadc_pkg::SCALE_W;

  state_e                       state_q;
  logic [ADC_BITS-1:0]          code_q;
  logic [tadc_pkg::MV_W-1:0]    mv_q;
  logic [tadc_pkg::NUM_W-1:0]   num_q;
  logic [tadc_pkg::DEN_W-1:0]   den_q;
  tadc_pkg::seg_info_t          seg_q;
  logic [tadc_pkg::NUM2_W-1:0]  num2_q;
  logic [tadc_pkg::T_W-1:0]     t_q;
  logic                         ok_q;
  logic [tadc_pkg::T_W-1:0]     held_q;
  logic                         out_valid_q;
  logic [tadc_pkg::T_W-1:0]     temp_q;
  logic                         inr_q;

  logic [PROD_W-1:0]            mv_prod;
  logic [NUM_PROD_W-1:0]        num_prod;
  logic [PROD2_W-1:0]           prod2;
  logic [tadc_pkg::DEN_W-1:0]   num_hi;
  logic                         ovf;
  logic                         out_free;
  tadc_pkg::div_req_t           div_req;
  tadc_pkg::div_rsp_t           div_rsp;
  tadc_pkg::seg_info_t          seg_info;

  // code to millivolts, and 10000*mv for the divider
  assign mv_prod  = PROD_W'(code_q) * PROD_W'(tadc_pkg::VREF_MV);
  assign num_prod = NUM_PROD_W'(mv_q) * NUM_PROD_W'(tadc_pkg::SERIES_OHM);

  // a quotient of 2^16 or more lies above every segment
  assign num_hi = tadc_pkg::DEN_W'(num_q[tadc_pkg::NUM_W-1:tadc_pkg::Q_W]);
  assign ovf    = num_hi >= den_q;

  // offset into the segment scaled by 100 or 1000
  assign prod2 = PROD2_W'(seg_q.diff) *
                 PROD2_W'(seg_q.fine ? tadc_pkg::SCALE_HI : tadc_pkg::SCALE_LO);

  // the result register can take a word
  assign out_free = !out_valid_q || temp_o.ready;

  // divider requests for the resistance and the temperature passes
  always_comb begin
    div_req = '0;
    case (state_q)
      S_D1: begin
        div_req.start = !ovf;
        div_req.hi    = num_hi;
        div_req.lo    = num_q[tadc_pkg::Q_W-1:0];
        div_req.cnt   = tadc_pkg::CNT_W'(tadc_pkg::Q_W);
        div_req.den   = den_q;
      end
      S_D2: begin
        div_req.start = 1'b1;
        div_req.hi    = num2_q[tadc_pkg::NUM2_W-1:tadc_pkg::QT_W];
        div_req.lo    = {num2_q[tadc_pkg::QT_W-1:0], (tadc_pkg::Q_W-tadc_pkg::QT_W)'(0)};
        div_req.cnt   = tadc_pkg::CNT_W'(tadc_pkg::QT_W);
        div_req.den   = seg_q.slope;
      end
      default: div_req = '0;
    endcase
  end

  tadc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tadc_seg u_seg (
    .r_i   (div_rsp.quot),
    .seg_o (seg_info)
  );

  // sequencer, held temperature and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= '0;
      mv_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      seg_q       <= '0;
      num2_q      <= '0;
      t_q         <= '0;
      ok_q        <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      temp_q      <= '0;
      inr_q       <= 1'b0;
    end else begin
      // word taken by the sink; a new word loaded below takes its place
      if (out_valid_q && temp_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (adc_i.valid) begin
            code_q  <= ADC_BITS'(adc_i.adc_code);
            state_q <= S_MV;
          end
        end
        S_MV: begin
          mv_q    <= mv_prod[PROD_W-1:ADC_BITS];
          state_q <= S_NUM;
        end
        S_NUM: begin
          num_q   <= num_prod[tadc_pkg::NUM_W-1:0];
          den_q   <= tadc_pkg::DEN_W'(tadc_pkg::VREF_MV - mv_q);
          state_q <= S_D1;
        end
        S_D1: begin
          ok_q    <= 1'b0;
          state_q <= ovf ? S_OUT : S_W1;
        end
        S_W1: begin
          if (div_rsp.done) begin
            seg_q   <= seg_info;
            ok_q    <= seg_info.hit;
            state_q <= S_SEG;
          end
        end
        S_SEG: begin
          state_q <= ok_q ? S_MUL : S_OUT;
        end
        S_MUL: begin
          num2_q  <= prod2[tadc_pkg::NUM2_W-1:0];
          state_q <= S_D2;
        end
        S_D2: begin
          state_q <= S_W2;
        end
        S_W2: begin
          if (div_rsp.done) begin
            t_q     <= tadc_pkg::T_W'(div_rsp.quot[tadc_pkg::QT_W-1:0]) + seg_q.base;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            inr_q       <= ok_q;
            temp_q      <= ok_q ? t_q : held_q;
            if (ok_q) begin
              held_q <= t_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign adc_i.ready       = (state_q == S_IDLE);
  assign temp_o.valid      = out_valid_q;
  assign temp_o.temp_centi = temp_q;
  assign temp_o.in_range   = inr_q;

  // checks
  `TADC_ASSERT_NOW(a_out_matches_held, temp_o.valid, temp_o.temp_centi == held_q)
  `TADC_ASSERT_NOW(a_held_bounded, 1'b1, held_q <= tadc_pkg::T_MAX)
  `TADC_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_q == S_W1 || state_q == S_W2)
  `TADC_ASSERT_NEXT(a_temp_pass_ok, state_q == S_W2 && div_rsp.done, state_q == S_OUT && ok_q)

endmodule

// ===== design/tadc_div.sv =====
// restoring divider, one quotient bit per cycle, narrow remainder datapath
// depends on tadc_pkg
`timescale 1ns / 1ps

module tadc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tadc_pkg::div_req_t req_i,
  output tadc_pkg::div_rsp_t rsp_o
);

  logic [tadc_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [tadc_pkg::DEN_W-1:0] den_q;
  logic [tadc_pkg::Q_W-1:0]   lo_q;
  logic [tadc_pkg::Q_W-1:0]   quot_q;
  logic [tadc_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [tadc_pkg::DEN_W:0]   trial;
  logic                       ge;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, lo_q[tadc_pkg::Q_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? tadc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[tadc_pkg::DEN_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.cnt;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == tadc_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder, dividend and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.hi;
      lo_q   <= req_i.lo;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[tadc_pkg::Q_W-2:0], 1'b0};
      quot_q <= {quot_q[tadc_pkg::Q_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== design/tadc_seg.sv =====
// resistance to segment lookup: bounds compare and offset into the segment
// depends on tadc_pkg
`timescale 1ns / 1ps

module tadc_seg (
  input  logic [tadc_pkg::R_W-1:0] r_i,
  output tadc_pkg::seg_info_t      seg_o
);

  // segments are disjoint, so at most one matches
  always_comb begin
    seg_o = '0;
    for (int i = 0; i < tadc_pkg::SEG_N; i++) begin
      if (r_i < tadc_pkg::SEG_TOP[i] && r_i > tadc_pkg::SEG_BOT[i]) begin
        seg_o.hit   = 1'b1;
        seg_o.diff  = tadc_pkg::DIFF_W'(tadc_pkg::SEG_TOP[i] - r_i);
        seg_o.fine  = tadc_pkg::SEG_FINE[i];
        seg_o.slope = tadc_pkg::SEG_SLOPE[i];
        seg_o.base  = tadc_pkg::SEG_BASE[i];
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the thermistor adc to temperature converter
// depends on tadc_pkg, the tadc channel interfaces and the converter rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int ADC_BITS   = tadc_pkg::ADC_BITS_DEF;
  localparam int CODE_W     = tadc_pkg::ADC_CODE_W;
  localparam int TEMP_W     = tadc_pkg::T_W;
  localparam int BANDS      = 6;
  localparam int NO_BAND    = -1;
  localparam int STALL_MAX  = 14;
  localparam int WAIT_LIMIT = 2000;
  localparam int TAIL_WAIT  = 40;
  localparam int RANDOM_N   = 750;
  localparam int QUIET_N    = 150;

  // resistance bands, hottest last; each band is open at both ends
  localparam int unsigned BAND_TOP   [BANDS] = '{33970, 20310, 12570, 8034, 5298, 3586};
  localparam int unsigned BAND_BOT   [BANDS] = '{20310, 12570, 8034, 5298, 3586, 2484};
  localparam int unsigned BAND_SCALE [BANDS] = '{100, 100, 1000, 1000, 1000, 1000};
  localparam int unsigned BAND_SLOPE [BANDS] = '{1366, 774, 4537, 2737, 1717, 1102};
  localparam int unsigned BAND_BASE  [BANDS] = '{0, 1000, 2000, 3000, 4000, 5000};

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [TEMP_W-1:0] temp_centi;
    logic              in_range;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  tadc_in_if  adc_ch ();
  tadc_out_if temp_ch ();

  thermistor_adc_to_temperature #(
    .ADC_BITS (ADC_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adc_i  (adc_ch),
    .temp_o (temp_ch)
  );

  reading_t          expected_readings [$];
  reading_t          got;
  logic [TEMP_W-1:0] held_centi;
  logic [CODE_W-1:0] band_codes [BANDS][$];
  logic [CODE_W-1:0] edge_codes [$];
  int                error_count = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;
  bit                idling_on;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // divider resistance for one code, all ones when the divider is at full scale
  function automatic logic [31:0] divider_ohms(input logic [CODE_W-1:0] code);
    logic [31:0] mv;
    mv = (32'(code) * 32'd3300) >> ADC_BITS;
    if (mv >= 32'd3300) return '1;
    return (32'd10000 * mv) / (32'd3300 - mv);
  endfunction

  function automatic int band_of(input logic [31:0] ohms);
    for (int b = 0; b < BANDS; b++) begin
      if (ohms < BAND_TOP[b] && ohms > BAND_BOT[b]) return b;
    end
    return NO_BAND;
  endfunction

  function automatic bit on_band_edge(input logic [31:0] ohms);
    for (int b = 0; b < BANDS; b++) begin
      if (ohms == BAND_TOP[b] || ohms == BAND_BOT[b]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected temperature word for one accepted code, updates the held value
  function automatic reading_t convert_reading(input logic [CODE_W-1:0] code);
    reading_t    rd;
    logic [31:0] ohms;
    logic [31:0] centi;
    int          b;
    ohms = divider_ohms(code);
    b = band_of(ohms);
    rd.code = code;
    rd.in_range = (b != NO_BAND);
    if (rd.in_range) begin
      centi = (BAND_TOP[b] - ohms) * BAND_SCALE[b] / BAND_SLOPE[b] + BAND_BASE[b];
      held_centi = centi[TEMP_W-1:0];
    end
    rd.temp_centi = held_centi;
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [CODE_W-1:0] code,
                                 input int got_v, input int exp_v);
    $display("mismatch %s: code %0d got %0d expected %0d", what, code, got_v, exp_v);
    error_count++;
  endtask

  // input side drops valid and waits
  task automatic hold_input(input int cycles);
    adc_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // send one adc word and record its expected result at acceptance
  task automatic send_code(input logic [CODE_W-1:0] code);
    if (idling_on && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, STALL_MAX));
    adc_ch.valid    <= 1'b1;
    adc_ch.adc_code <= code;
    @(posedge clk_i);
    while (!adc_ch.ready) @(posedge clk_i);
    expected_readings.push_back(convert_reading(code));
  endtask

  task automatic wait_all_results();
    hold_input(1);
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // sort every code by the band its resistance falls in
  task automatic classify_codes();
    logic [31:0] ohms;
    int          b;
    for (int c = 0; c < (1 << CODE_W); c++) begin
      ohms = divider_ohms(c[CODE_W-1:0]);
      b = band_of(ohms);
      if (b != NO_BAND) band_codes[b].push_back(c[CODE_W-1:0]);
      if (on_band_edge(ohms)) edge_codes.push_back(c[CODE_W-1:0]);
    end
  endtask

  function automatic logic [CODE_W-1:0] pick_band_code(input int b);
    return band_codes[b][$urandom_range(0, band_codes[b].size() - 1)];
  endfunction

  // out-of-range words before any valid reading must report zero
  task automatic test_cold_start();
    send_code('0);
    send_code(CODE_W'(1));
    send_code('1);
    send_code('1 - CODE_W'(1));
  endtask

  // one word from the middle of each band, then the ends of the whole span and the midscale code
  task automatic test_bands();
    for (int b = 0; b < BANDS; b++) send_code(band_codes[b][band_codes[b].size() / 2]);
    send_code(band_codes[0][band_codes[0].size() - 1]);
    send_code(band_codes[BANDS-1][0]);
    send_code(CODE_W'(1 << (CODE_W - 1)));
    wait_all_results();
  endtask

  // a resistance exactly on a band edge keeps the previous temperature
  task automatic test_band_edges();
    foreach (edge_codes[i]) begin
      send_code(pick_band_code($urandom_range(0, BANDS - 1)));
      send_code(edge_codes[i]);
    end
  endtask

  // mostly in-band words, some near band edges, the rest anywhere
  task automatic test_random();
    int                sel;
    logic [CODE_W-1:0] code;
    for (int n = 0; n < RANDOM_N; n++) begin
      if (n == RANDOM_N - QUIET_N) idling_on = 1'b0;
      if (n == RANDOM_N / 2) wait_all_results();
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        code = pick_band_code($urandom_range(0, BANDS - 1));
      end else if (sel < 75 && edge_codes.size() != 0) begin
        code = edge_codes[$urandom_range(0, edge_codes.size() - 1)]
               + CODE_W'($urandom_range(0, 4)) - CODE_W'(2);
      end else begin
        code = CODE_W'($urandom_range(0, (1 << CODE_W) - 1));
      end
      send_code(code);
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      temp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      temp_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, STALL_MAX) - 1;
      temp_ch.ready <= 1'b0;
    end else begin
      temp_ch.ready <= 1'b1;
    end
  end

  // compare each accepted temperature word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && temp_ch.valid && temp_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected word", '0, temp_ch.temp_centi, 0);
      end else begin
        got = expected_readings.pop_front();
        if (temp_ch.temp_centi !== got.temp_centi)
          report_mismatch("temp_centi", got.code, temp_ch.temp_centi, got.temp_centi);
        if (temp_ch.in_range !== got.in_range)
          report_mismatch("in_range", got.code, temp_ch.in_range, got.in_range);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((adc_ch.valid && adc_ch.ready) || (temp_ch.valid && temp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WAIT_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni          = 1'b0;
    adc_ch.valid    = 1'b0;
    adc_ch.adc_code = '0;
    held_centi      = '0;
    idling_on       = 1'b1;
    classify_codes();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cold_start();
    test_bands();
    test_band_edges();
    test_random();

    wait_all_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
